[src/mmddf_pkg.sv]
// ----------------------------------------------------------------------------
// mmddf_pkg
// Types, constants and conversion helpers for the decimal display formatter.
// ----------------------------------------------------------------------------
package mmddf_pkg;

    localparam int DIG_CNT    = 8;
    localparam int FREQ_W     = 27;
    localparam int BCD_DIGITS = 9;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    // double-dabble steps per pipeline stage
    localparam int DD_STEPS   = 7;
    localparam int DD_STAGES  = (FREQ_W + DD_STEPS - 1) / DD_STEPS;
    // input register, conversion stages, output register
    localparam int NUM_STG    = DD_STAGES + 2;

    localparam logic [3:0] BLANK    = 4'd10;
    localparam logic [3:0] DUTY_MAX = 4'd9;
    localparam logic [9:0] TEMP_MAX = 10'd999;

    localparam logic [2:0] MODE_CLOCK = 3'd0;
    localparam logic [2:0] MODE_TEMP  = 3'd1;
    localparam logic [2:0] MODE_VOLT  = 3'd2;
    localparam logic [2:0] MODE_DIST  = 3'd3;
    localparam logic [2:0] MODE_FREQ  = 3'd4;
    localparam logic [2:0] MODE_DUTY  = 3'd5;

    localparam logic [7:0] MASK_CLOCK = 8'b0010_0100;
    localparam logic [7:0] MASK_TEMP  = 8'b0000_0010;
    localparam logic [7:0] MASK_VOLT  = 8'b0100_0001;

    typedef struct packed {
        logic [4:0]        hours;
        logic [5:0]        minutes;
        logic [5:0]        seconds;
        logic [9:0]        temperature_tenths;
        logic [5:0]        voltage_a_tenths;
        logic [5:0]        voltage_b_tenths;
        logic [7:0]        distance_cm;
        logic [FREQ_W-1:0] frequency_hz;
        logic [3:0]        duty_level;
    } t_in;

    typedef struct packed {
        logic [3:0] digit0;
        logic [3:0] digit1;
        logic [3:0] digit2;
        logic [3:0] digit3;
        logic [3:0] digit4;
        logic [3:0] digit5;
        logic [3:0] digit6;
        logic [3:0] digit7;
        logic [7:0] point_mask;
    } t_out;

    // dig[0] is the leftmost position
    typedef struct packed {
        logic [DIG_CNT-1:0][3:0] dig;
        logic [7:0]              mask;
    } t_disp;

    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [FREQ_W-1:0] bin;
    } t_dd;

    typedef struct packed {
        t_disp disp;
        t_dd   dd;
    } t_stg;

    // exact for v < 1029
    function automatic logic [6:0] div10(input logic [9:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[17:11];
    endfunction

    // exact for v < 1000
    function automatic logic [3:0] div100(input logic [9:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd41;
        return p[15:12];
    endfunction

    function automatic logic [3:0] mod10(input logic [9:0] v);
        logic [9:0] q;
        q = {3'b000, div10(v)};
        return 4'(v - q * 10'd10);
    endfunction

    function automatic logic [3:0] tens(input logic [9:0] v);
        return 4'(div10(v));
    endfunction

    function automatic t_dd dd_step(input t_dd st);
        t_dd r;
        r = st;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r.bcd[4*i +: 4] >= 4'd5) begin
                r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
            end
        end
        r.bcd = {r.bcd[BCD_W-2:0], r.bin[FREQ_W-1]};
        r.bin = {r.bin[FREQ_W-2:0], 1'b0};
        return r;
    endfunction

    function automatic t_dd dd_run(input t_dd st, input int n);
        t_dd r;
        r = st;
        for (int j = 0; j < DD_STEPS; j++) begin
            if (j < n) begin
                r = dd_step(r);
            end
        end
        return r;
    endfunction

    // every layout except frequency
    function automatic t_disp fmt_small(input t_in d, input logic [2:0] mode);
        t_disp      r;
        logic [9:0] t;
        logic [6:0] q10;
        logic [3:0] q100;
        for (int i = 0; i < DIG_CNT; i++) begin
            r.dig[i] = BLANK;
        end
        r.mask = '0;
        t      = '0;
        q10    = '0;
        q100   = '0;
        case (mode)
            MODE_CLOCK: begin
                r.dig[0] = tens(10'(d.hours));
                r.dig[1] = mod10(10'(d.hours));
                r.dig[3] = tens(10'(d.minutes));
                r.dig[4] = mod10(10'(d.minutes));
                r.dig[6] = tens(10'(d.seconds));
                r.dig[7] = mod10(10'(d.seconds));
                r.mask   = MASK_CLOCK;
            end
            MODE_TEMP, MODE_DIST: begin
                if (mode == MODE_TEMP) begin
                    t = (d.temperature_tenths > TEMP_MAX) ? TEMP_MAX
                                                          : d.temperature_tenths;
                    r.mask = MASK_TEMP;
                end else begin
                    t = 10'(d.distance_cm);
                end
                q10      = div10(t);
                q100     = div100(t);
                r.dig[0] = q100;
                r.dig[1] = 4'(q10 - {3'b000, q100} * 7'd10);
                r.dig[2] = mod10(t);
            end
            MODE_VOLT: begin
                r.dig[0] = tens(10'(d.voltage_a_tenths));
                r.dig[1] = mod10(10'(d.voltage_a_tenths));
                r.dig[6] = tens(10'(d.voltage_b_tenths));
                r.dig[7] = mod10(10'(d.voltage_b_tenths));
                r.mask   = MASK_VOLT;
            end
            MODE_DUTY: begin
                r.dig[0] = (d.duty_level > DUTY_MAX) ? DUTY_MAX : d.duty_level;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // low eight BCD digits with leading-zero blanking; the ninth digit
    // only takes part in the blanking
    function automatic t_disp fmt_freq(input logic [BCD_W-1:0] bcd);
        t_disp r;
        logic  nz;
        nz = (bcd[BCD_W-1 -: 4] != 4'd0);
        for (int i = 0; i < DIG_CNT; i++) begin
            nz       = nz | (bcd[4*(DIG_CNT-1-i) +: 4] != 4'd0);
            r.dig[i] = nz ? bcd[4*(DIG_CNT-1-i) +: 4] : BLANK;
        end
        r.mask = '0;
        return r;
    endfunction

endpackage

[src/multi_mode_decimal_display_formatter.sv]
// ----------------------------------------------------------------------------
// multi_mode_decimal_display_formatter
// Turns measured values into eight digit codes (10 = blank) and a
// decimal-point mask for an eight-digit display, in one of six layouts.
// ----------------------------------------------------------------------------
// Usage: one transaction in gives one transaction out, in order. The block
// takes a new transaction every cycle while the output is not stalled, and
// passes each result through the input register, four binary-to-BCD stages
// and the output register; the depth is set by the 27-bit frequency
// conversion, done as up to seven shift-and-adjust steps per stage. Every
// stage holds its item independently, so a stalled output only backs up the
// stages that are full. The layout comes from the display_mode register; the
// user must write it through the cfg channel while no transaction is in flight,
// which the block does not enforce. Codes 6 and 7 give an all-blank display.
module multi_mode_decimal_display_formatter
    import mmddf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    logic [2:0]         r_mode;
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_rdy;
    t_in                r_in;
    t_stg               r_stg [1:DD_STAGES];
    t_stg               n_stg [1:DD_STAGES];
    t_out               r_out;
    t_out               n_out;
    t_disp              w_disp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[NUM_STG-1];
    assign o_out_data  = r_out;

    // a stage can load when it is empty or its item moves on
    always_comb begin
        w_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        t_dd st;
        int  steps;
        for (int k = 1; k <= DD_STAGES; k++) begin
            steps = FREQ_W - DD_STEPS * (k - 1);
            if (steps > DD_STEPS) begin
                steps = DD_STEPS;
            end
            if (k == 1) begin
                st.bcd          = '0;
                st.bin          = r_in.frequency_hz;
                n_stg[k].disp   = fmt_small(r_in, r_mode);
            end else begin
                st              = r_stg[k-1].dd;
                n_stg[k].disp   = r_stg[k-1].disp;
            end
            n_stg[k].dd = dd_run(st, steps);
        end
    end

    always_comb begin
        if (r_mode == MODE_FREQ) begin
            w_disp = fmt_freq(r_stg[DD_STAGES].dd.bcd);
        end else begin
            w_disp = r_stg[DD_STAGES].disp;
        end
        n_out.digit0     = w_disp.dig[0];
        n_out.digit1     = w_disp.dig[1];
        n_out.digit2     = w_disp.dig[2];
        n_out.digit3     = w_disp.dig[3];
        n_out.digit4     = w_disp.dig[4];
        n_out.digit5     = w_disp.dig[5];
        n_out.digit6     = w_disp.dig[6];
        n_out.digit7     = w_disp.dig[7];
        n_out.point_mask = w_disp.mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CLOCK;
            r_vld  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_in <= i_in_data;
        end
        for (int k = 1; k <= DD_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (w_rdy[NUM_STG-1]) begin
            r_out <= n_out;
        end
    end

endmodule

[src/mmddf_checker.sv]
// ----------------------------------------------------------------------------
// mmddf_checker
// Port-level checks for the decimal display formatter, bound to the top.
// ----------------------------------------------------------------------------
module mmddf_checker
    import mmddf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out       o_out_data
);

    // a result under backpressure stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped under backpressure");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // no layout lights the points of positions 3, 4 or 7
    a_mask_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.point_mask & 8'b1001_1000) == 8'd0)
        else $error("decimal point on an unused position");

    // clock layout: the dotted positions are separators
    a_clock_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.point_mask[2] |->
            o_out_data.digit2 == BLANK && o_out_data.digit5 == BLANK)
        else $error("clock separator not blank");

    // voltage layout: the middle of the display is blank
    a_volt_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.point_mask[6] |->
            o_out_data.digit2 == BLANK && o_out_data.digit3 == BLANK &&
            o_out_data.digit4 == BLANK && o_out_data.digit5 == BLANK)
        else $error("voltage layout middle not blank");

endmodule

bind multi_mode_decimal_display_formatter mmddf_checker u_mmddf_checker (.*);
